FILE: hdl/flrp_pkg.sv
// ----------------------------------------------------------------------------
// flrp_pkg
// Shared types and constants of the file list record parser.
// ----------------------------------------------------------------------------
package flrp_pkg;

   localparam int TYPE_BYTES = 1;

   localparam logic [3:0] TYPE_LEN = (TYPE_BYTES < 1) ? 4'd1 :
                                     (TYPE_BYTES > 8) ? 4'd8 : 4'(TYPE_BYTES);
   localparam logic [3:0] WORD_LEN = 4'd8;

   typedef enum logic [1:0] {
      KIND_HEADER   = 2'd0,
      KIND_NAME     = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_ERROR    = 2'd3
   } flrp_kind_type;

   // results of one request: a first result and an optional second one,
   // which is always list complete or truncation error
   typedef struct packed {
      flrp_kind_type kind;
      logic [7:0]    entry_type;
      logic [63:0]   entry_size;
      logic [63:0]   name_length;
      logic [7:0]    name_byte;
      logic          last_name_byte;
      logic [2:0]    error_field;
      logic          has_second;
      flrp_kind_type second_kind;
      logic [2:0]    second_error;
   } flrp_step_type;

   typedef struct packed {
      logic full;
      logic empty;
   } flrp_queue_status_type;

endpackage

FILE: hdl/flrp_req_if.sv
// ----------------------------------------------------------------------------
// flrp_req_if
// Request channel: one buffer byte per request.
// ----------------------------------------------------------------------------
interface flrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

FILE: hdl/flrp_rsp_if.sv
// ----------------------------------------------------------------------------
// flrp_rsp_if
// Result channel: headers, name bytes, list complete and truncation errors.
// ----------------------------------------------------------------------------
interface flrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  entry_type;
   logic [63:0] entry_size;
   logic [63:0] name_length;
   logic [7:0]  name_byte;
   logic        last_name_byte;
   logic [2:0]  error_field;

   modport source (output valid, output kind, output entry_type, output entry_size,
                   output name_length, output name_byte, output last_name_byte,
                   output error_field, input ready);
   modport sink   (input valid, input kind, input entry_type, input entry_size,
                   input name_length, input name_byte, input last_name_byte,
                   input error_field, output ready);
endinterface

FILE: hdl/file_list_record_parser.sv
// ----------------------------------------------------------------------------
// file_list_record_parser
// Byte-serial parser of a serialized file list into headers, name bytes,
// list complete and truncation error results.
// Flow: one request per cycle while the queue is not full; results leave
//   at one per cycle while the result channel is ready.
// Path: a record enters the two-entry queue at the accepting edge and moves
//   into the output register at the next edge once that register is free;
//   waiting results and result stalls hold it back.
// Reset: synchronous; parser returns to expecting the entry count and the
//   queue and output register are emptied.
// ----------------------------------------------------------------------------
module file_list_record_parser
   import flrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   flrp_req_if.sink     req_chan,
   flrp_rsp_if.source   rsp_chan
);

   logic                  push;
   flrp_step_type         push_data;
   logic                  pop;
   flrp_step_type         pop_data;
   flrp_queue_status_type queue_status;

   flrp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   flrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   flrp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

FILE: hdl/flrp_front.sv
// ----------------------------------------------------------------------------
// flrp_front
// Byte parser: gathers fields, tracks entries and builds the results of
// each request for the queue.
// ----------------------------------------------------------------------------
module flrp_front
   import flrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   flrp_req_if.sink              req_chan,
   input  flrp_queue_status_type queue_status,
   output logic                  push,
   output flrp_step_type         push_data
);

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_TYPE  = 3'd1,
      PH_SIZE  = 3'd2,
      PH_NLEN  = 3'd3,
      PH_NAME  = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] entries_ff, entries_in;
   logic [63:0] name_left_ff, name_left_in;
   logic [7:0]  type_ff, type_in;
   logic [63:0] size_ff, size_in;

   logic          accept;
   logic [3:0]    idx_plus;
   logic [3:0]    field_len;
   logic          field_full;
   logic [63:0]   acc_gather;
   logic [63:0]   name_dec;
   logic          first_valid;
   flrp_step_type step;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign idx_plus   = {1'b0, idx_ff} + 4'd1;
   assign field_len  = (phase_ff == PH_TYPE) ? TYPE_LEN : WORD_LEN;
   assign field_full = idx_plus >= field_len;
   assign acc_gather = acc_ff | (64'(req_chan.data_byte) << {idx_ff, 3'b000});
   assign name_dec   = name_left_ff - 64'd1;

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      entries_in   = entries_ff;
      name_left_in = name_left_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      first_valid  = 1'b0;
      step         = '0;
      step.kind        = KIND_HEADER;
      step.second_kind = KIND_COMPLETE;

      if (phase_ff == PH_COUNT || phase_ff == PH_TYPE ||
          phase_ff == PH_SIZE || phase_ff == PH_NLEN) begin
         idx_in = field_full ? 3'd0 : idx_plus[2:0];
         acc_in = field_full ? 64'd0 : acc_gather;
      end

      unique case (phase_ff)
         PH_COUNT: begin
            if (field_full) begin
               entries_in = acc_gather;
               if (acc_gather == 64'd0) begin
                  phase_in    = PH_DONE;
                  first_valid = 1'b1;
                  step.kind   = KIND_COMPLETE;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            if (field_full) begin
               type_in  = acc_gather[7:0];
               phase_in = PH_SIZE;
            end
         end
         PH_SIZE: begin
            if (field_full) begin
               size_in  = acc_gather;
               phase_in = PH_NLEN;
            end
         end
         PH_NLEN: begin
            if (field_full) begin
               first_valid      = 1'b1;
               step.kind        = KIND_HEADER;
               step.entry_type  = type_ff;
               step.entry_size  = size_ff;
               step.name_length = acc_gather;
               name_left_in     = acc_gather;
               if (acc_gather == 64'd0) begin
                  entries_in = entries_ff - 64'd1;
                  if (entries_ff == 64'd1) begin
                     phase_in         = PH_DONE;
                     step.has_second  = 1'b1;
                     step.second_kind = KIND_COMPLETE;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end else begin
                  phase_in = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            name_left_in        = name_dec;
            first_valid         = 1'b1;
            step.kind           = KIND_NAME;
            step.name_byte      = req_chan.data_byte;
            step.last_name_byte = (name_dec == 64'd0);
            if (name_dec == 64'd0) begin
               entries_in = entries_ff - 64'd1;
               if (entries_ff == 64'd1) begin
                  phase_in         = PH_DONE;
                  step.has_second  = 1'b1;
                  step.second_kind = KIND_COMPLETE;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (req_chan.stream_end) begin
         if (phase_in != PH_DONE) begin
            if (first_valid) begin
               step.has_second   = 1'b1;
               step.second_kind  = KIND_ERROR;
               step.second_error = phase_in;
            end else begin
               first_valid      = 1'b1;
               step.kind        = KIND_ERROR;
               step.error_field = phase_in;
            end
         end
         phase_in     = PH_COUNT;
         idx_in       = 3'd0;
         acc_in       = 64'd0;
         entries_in   = 64'd0;
         name_left_in = 64'd0;
         type_in      = 8'd0;
         size_in      = 64'd0;
      end
   end

   assign push      = accept && first_valid;
   assign push_data = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         idx_ff       <= 3'd0;
         acc_ff       <= 64'd0;
         entries_ff   <= 64'd0;
         name_left_ff <= 64'd0;
         type_ff      <= 8'd0;
         size_ff      <= 64'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         entries_ff   <= entries_in;
         name_left_ff <= name_left_in;
         type_ff      <= type_in;
         size_ff      <= size_in;
      end
   end

endmodule

FILE: hdl/flrp_queue.sv
// ----------------------------------------------------------------------------
// flrp_queue
// Two-entry queue of per-request result records between front and back.
// ----------------------------------------------------------------------------
module flrp_queue
   import flrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  flrp_step_type         push_data,
   input  logic                  pop,
   output flrp_step_type         pop_data,
   output flrp_queue_status_type status
);

   flrp_step_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a push");

endmodule

FILE: hdl/flrp_back.sv
// ----------------------------------------------------------------------------
// flrp_back
// Result sequencer: unpacks each record into one or two results and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module flrp_back
   import flrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  flrp_queue_status_type queue_status,
   input  flrp_step_type         pop_data,
   output logic                  pop,
   flrp_rsp_if.source            rsp_chan
);

   flrp_step_type cur_ff, cur_in;
   logic          valid_ff, valid_in;
   logic          sel_ff, sel_in;
   logic          take;
   logic          to_second;
   logic          need_load;

   assign take      = valid_ff && rsp_chan.ready;
   assign to_second = !sel_ff && cur_ff.has_second;
   assign need_load = !valid_ff || (take && !to_second);
   assign pop       = need_load && !queue_status.empty;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (pop) begin
         cur_in   = pop_data;
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (need_load) begin
         valid_in = 1'b0;
      end else if (take) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.kind           = sel_ff ? cur_ff.second_kind : cur_ff.kind;
   assign rsp_chan.entry_type     = sel_ff ? 8'd0 : cur_ff.entry_type;
   assign rsp_chan.entry_size     = sel_ff ? 64'd0 : cur_ff.entry_size;
   assign rsp_chan.name_length    = sel_ff ? 64'd0 : cur_ff.name_length;
   assign rsp_chan.name_byte      = sel_ff ? 8'd0 : cur_ff.name_byte;
   assign rsp_chan.last_name_byte = sel_ff ? 1'b0 : cur_ff.last_name_byte;
   assign rsp_chan.error_field    = sel_ff ? cur_ff.second_error : cur_ff.error_field;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the file list record parser. Builds serialized
// file lists byte by byte: well-formed lists, lists cut at every field,
// trailing bytes and random noise. A behavioral parser predicts the headers,
// name bytes, list complete and truncation error results, and a scoreboard
// checks them in order while both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
   import flrp_pkg::*;

   typedef enum logic [2:0] {
      AT_COUNT = 3'd0,
      AT_TYPE  = 3'd1,
      AT_SIZE  = 3'd2,
      AT_NLEN  = 3'd3,
      AT_NAME  = 3'd4,
      AT_DONE  = 3'd5
   } parse_stage_type;

   typedef struct {
      flrp_kind_type kind;
      logic [7:0]    entry_type;
      logic [63:0]   entry_size;
      logic [63:0]   name_length;
      logic [7:0]    name_byte;
      logic          last_name_byte;
      logic [2:0]    error_field;
   } parse_result_type;

   logic clock = 1'b0;
   logic reset;

   flrp_req_if req_chan();
   flrp_rsp_if rsp_chan();

   file_list_record_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   parse_stage_type  stage;
   logic [3:0]       field_index;
   logic [63:0]      field_acc;
   logic [63:0]      entries_left;
   logic [63:0]      name_left;
   logic [7:0]       held_type;
   logic [63:0]      held_size;

   parse_result_type pending_results[$];
   parse_result_type head;
   logic [7:0]       listing[$];
   int               mismatches = 0;
   int               stall_left = 0;
   bit               gaps_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void restart_parser();
      stage        = AT_COUNT;
      field_index  = 4'd0;
      field_acc    = 64'd0;
      entries_left = 64'd0;
      name_left    = 64'd0;
      held_type    = 8'd0;
      held_size    = 64'd0;
   endfunction

   function automatic void note_result(flrp_kind_type k, logic [7:0] ty, logic [63:0] sz,
                                       logic [63:0] nl, logic [7:0] nb, logic lb,
                                       logic [2:0] ef);
      parse_result_type r;
      r.kind           = k;
      r.entry_type     = ty;
      r.entry_size     = sz;
      r.name_length    = nl;
      r.name_byte      = nb;
      r.last_name_byte = lb;
      r.error_field    = ef;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic logic gather_byte(logic [7:0] b, logic [3:0] len);
      field_acc   = field_acc | (64'(b) << (8 * field_index[2:0]));
      field_index = field_index + 4'd1;
      if (field_index >= len) begin
         field_index = 4'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void finish_entry();
      entries_left = entries_left - 64'd1;
      if (entries_left == 64'd0) begin
         stage = AT_DONE;
         note_result(KIND_COMPLETE, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0);
      end else begin
         stage = AT_TYPE;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic is_last);
      case (stage)
         AT_COUNT: begin
            if (gather_byte(b, WORD_LEN)) begin
               entries_left = field_acc;
               field_acc    = 64'd0;
               if (entries_left == 64'd0) begin
                  stage = AT_DONE;
                  note_result(KIND_COMPLETE, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'd0);
               end else begin
                  stage = AT_TYPE;
               end
            end
         end
         AT_TYPE: begin
            if (gather_byte(b, TYPE_LEN)) begin
               held_type = field_acc[7:0];
               field_acc = 64'd0;
               stage     = AT_SIZE;
            end
         end
         AT_SIZE: begin
            if (gather_byte(b, WORD_LEN)) begin
               held_size = field_acc;
               field_acc = 64'd0;
               stage     = AT_NLEN;
            end
         end
         AT_NLEN: begin
            if (gather_byte(b, WORD_LEN)) begin
               note_result(KIND_HEADER, held_type, held_size, field_acc, 8'd0, 1'b0, 3'd0);
               name_left = field_acc;
               field_acc = 64'd0;
               if (name_left == 64'd0) begin
                  finish_entry();
               end else begin
                  stage = AT_NAME;
               end
            end
         end
         AT_NAME: begin
            name_left = name_left - 64'd1;
            note_result(KIND_NAME, 8'd0, 64'd0, 64'd0, b, name_left == 64'd0, 3'd0);
            if (name_left == 64'd0) begin
               finish_entry();
            end
         end
         default: begin
            stage = AT_DONE;
         end
      endcase
      if (is_last) begin
         if (stage != AT_DONE) begin
            note_result(KIND_ERROR, 8'd0, 64'd0, 64'd0, 8'd0, 1'b0, 3'(stage));
         end
         restart_parser();
      end
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void add_le(logic [63:0] value, int len);
      for (int i = 0; i < len; i++) begin
         listing.insert(listing.size(), value[8*i +: 8]);
      end
   endfunction

   function automatic void add_entry(logic [63:0] ty, logic [63:0] sz, logic [63:0] nl,
                                     int name_count);
      add_le(ty, TYPE_LEN);
      add_le(sz, WORD_LEN);
      add_le(nl, WORD_LEN);
      repeat (name_count) listing.insert(listing.size(), 8'($urandom));
   endfunction

   task automatic send_byte(logic [7:0] b, logic is_last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.stream_end <= is_last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      parse_byte(b, is_last);
   endtask

   // send the first keep bytes, the last one marked as stream end
   task automatic send_listing(int keep);
      if (keep > listing.size()) begin
         keep = listing.size();
      end
      for (int i = 0; i < keep; i++) begin
         send_byte(listing[i], i == keep - 1);
      end
      listing.delete();
   endtask

   task automatic test_count_field();
      gaps_on = 1'b1;
      add_le(64'h0000_0000_00FF_00FF, WORD_LEN);
      send_listing(3);
      add_le(64'd0, WORD_LEN);
      listing.insert(listing.size(), 8'hFF);
      listing.insert(listing.size(), 8'h00);
      send_listing(listing.size());
      add_le(64'd0, WORD_LEN);
      send_listing(listing.size());
   endtask

   task automatic test_short_entries();
      add_le(64'd1, WORD_LEN);
      add_entry('1, '1, 64'd0, 0);
      send_listing(listing.size());
      add_le(64'd2, WORD_LEN);
      add_entry(64'd0, 64'd0, 64'd2, 0);
      listing.insert(listing.size(), 8'h00);
      listing.insert(listing.size(), 8'hFF);
      send_listing(listing.size());
      add_le('1, WORD_LEN);
      add_entry(64'h5A, {$urandom, $urandom}, 64'd1, 1);
      send_listing(listing.size());
   endtask

   task automatic test_truncation_points();
      for (int cut = 4; cut <= 28 + TYPE_LEN; cut += 4) begin
         add_le(64'd1, WORD_LEN);
         add_entry(pick_word(), pick_word(), 64'd4, 4);
         send_listing(cut);
      end
   endtask

   task automatic test_random_listings();
      int sent;
      int entries;
      int nlen;
      int keep;
      int choice;
      sent = 0;
      while (sent < 680) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         choice  = $urandom_range(0, 9);
         if (choice < 8) begin
            entries = $urandom_range(0, 4);
            add_le(64'(entries), WORD_LEN);
            for (int e = 0; e < entries; e++) begin
               nlen = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
               if (choice == 7 && e == entries - 1) begin
                  add_entry(pick_word(), pick_word(), {$urandom, $urandom},
                            $urandom_range(0, 5));
               end else begin
                  add_entry(pick_word(), pick_word(), 64'(nlen), nlen);
               end
            end
            if (choice < 5) begin
               repeat ($urandom_range(0, 3)) listing.insert(listing.size(), 8'($urandom));
               keep = listing.size();
            end else begin
               keep = $urandom_range(1, listing.size());
            end
         end else begin
            repeat ($urandom_range(1, 40)) listing.insert(listing.size(), 8'($urandom));
            keep = listing.size();
         end
         sent += keep;
         send_listing(keep);
      end
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (3) begin
         add_le(64'd2, WORD_LEN);
         add_entry(pick_word(), pick_word(), 64'd3, 3);
         add_entry(pick_word(), pick_word(), 64'd3, 3);
         send_listing(listing.size());
      end
   endtask

   function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: kind expected none, actual %0d", $time, rsp_chan.kind);
            mismatches++;
         end else begin
            head = pending_results.pop_front();
            report_field("kind", 64'(head.kind), 64'(rsp_chan.kind));
            report_field("entry_type", 64'(head.entry_type), 64'(rsp_chan.entry_type));
            report_field("entry_size", head.entry_size, rsp_chan.entry_size);
            report_field("name_length", head.name_length, rsp_chan.name_length);
            report_field("name_byte", 64'(head.name_byte), 64'(rsp_chan.name_byte));
            report_field("last_name_byte", 64'(head.last_name_byte),
                         64'(rsp_chan.last_name_byte));
            report_field("error_field", 64'(head.error_field), 64'(rsp_chan.error_field));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      restart_parser();
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'd0;
      req_chan.stream_end <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_count_field();
      test_short_entries();
      test_truncation_points();
      test_random_listings();
      test_back_to_back();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
